// File: design/lgf_pkg.sv
// shared types and constants for the largest free gap finder
// no dependencies
`timescale 1ns / 1ps

package lgf_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int BLK_W       = 64;
   localparam int ENTRY_W     = 2 * BLK_W;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = BLK_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_USABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_USABLE  = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_NEXT,
      ST_SORT_KEY,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } seq_state_type;

   // one gap candidate [base, bound-1]
   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] base;
      logic [BLK_W-1:0] bound;
   } cand_type;

   typedef struct packed {
      logic             found;
      logic [BLK_W-1:0] gap_start;
      logic [BLK_W-1:0] gap_end;
   } best_type;

   typedef struct packed {
      logic             found;
      logic [BLK_W-1:0] gap_start;
      logic [BLK_W-1:0] gap_end;
      logic             overflow;
   } rsp_type;

endpackage

// File: design/largest_free_gap_finder.sv
// top level of the largest free gap finder: csr registers, result register
// depends on lgf_pkg, lgf_seq
//
//   port group | direction | handshake            | content
//   req_*      | in        | req_valid/req_ready  | one occupied range per transaction
//   rsp_*      | out       | rsp_valid/rsp_ready  | largest gap, one per set
//   csr_*      | in        | csr_wr_en            | first/last usable block
//
// loading accepts one transaction per cycle. after the last item the ranges are
// sorted in place in the range ram (single read and write port), shifting
// n*(n-1)/2 entries at worst; then scan, drain and result push follow, and the
// result push loads the output register.
// reset clears the set and the csr registers; the ram needs no clearing.
// req_ready is low from the last item until its result is in the output
// register; a stalled rsp holds the result while the next set loads.
`timescale 1ns / 1ps

module largest_free_gap_finder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_entry_valid,
   input  logic [lgf_pkg::BLK_W-1:0]     req_range_start,
   input  logic [lgf_pkg::BLK_W-1:0]     req_range_end,
   input  logic                          req_last_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [lgf_pkg::BLK_W-1:0]     rsp_gap_start,
   output logic [lgf_pkg::BLK_W-1:0]     rsp_gap_end,
   output logic                          rsp_overflow,
   input  logic                          csr_wr_en,
   input  logic [lgf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lgf_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import lgf_pkg::*;

   logic [BLK_W-1:0] first_usable_ff;
   logic [BLK_W-1:0] last_usable_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             rsp_slot_free;
   logic             rsp_push;
   rsp_type          rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
         last_usable_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_USABLE: first_usable_ff <= csr_wr_data;
            CSR_LAST_USABLE:  last_usable_ff  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   lgf_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_entry_valid (req_entry_valid),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_last_item   (req_last_item),
      .first_usable    (first_usable_ff),
      .last_usable     (last_usable_ff),
      .rsp_slot_free   (rsp_slot_free),
      .rsp_push        (rsp_push),
      .rsp_data        (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_push) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_ff.found;
   assign rsp_gap_start = rsp_ff.gap_start;
   assign rsp_gap_end   = rsp_ff.gap_end;
   assign rsp_overflow  = rsp_ff.overflow;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending transaction overwritten");
   a_ready_after_push: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> req_ready)
      else $error("input not reopened after result");
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_gap_start == '0) && (rsp_gap_end == '0))
      else $error("gap bounds nonzero without a gap");
`endif

endmodule

// File: design/lgf_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lgf_gap_eval.sv
// two stage gap evaluator: size of one candidate, then keep the first largest
// depends on lgf_pkg
`timescale 1ns / 1ps

module lgf_gap_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  lgf_pkg::cand_type cand,
   output logic              busy,
   output lgf_pkg::best_type best
);
   import lgf_pkg::*;

   logic             a_valid_ff;
   logic             a_ok_ff;
   logic [BLK_W-1:0] a_size_ff;
   logic [BLK_W-1:0] a_start_ff;
   logic [BLK_W-1:0] a_end_ff;
   logic [BLK_W-1:0] best_size_ff;
   logic [BLK_W-1:0] best_start_ff;
   logic [BLK_W-1:0] best_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cand.valid;
      end
      a_ok_ff    <= cand.bound > cand.base;
      a_size_ff  <= cand.bound - cand.base;
      a_start_ff <= cand.base;
      a_end_ff   <= cand.bound - BLK_W'(1);
   end

   // strict compare keeps the first gap among equal sizes
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         best_size_ff  <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
      end else if (a_valid_ff && a_ok_ff && (a_size_ff > best_size_ff)) begin
         best_size_ff  <= a_size_ff;
         best_start_ff <= a_start_ff;
         best_end_ff   <= a_end_ff;
      end
   end

   assign busy           = a_valid_ff;
   assign best.found     = best_size_ff != '0;
   assign best.gap_start = best_start_ff;
   assign best.gap_end   = best_end_ff;

`ifndef SYNTHESIS
   a_best_zero_when_empty: assert property (@(posedge clock) disable iff (reset)
      !best.found |-> (best_start_ff == '0) && (best_end_ff == '0))
      else $error("gap start or end nonzero without a gap");
   a_best_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(clear) && !$past(reset) |-> best_size_ff >= $past(best_size_ff))
      else $error("best gap size shrank during scan");
   a_best_ordered: assert property (@(posedge clock) disable iff (reset)
      best.found |-> best_end_ff >= best_start_ff)
      else $error("best gap end below its start");
`endif

endmodule

// File: design/lgf_seq.sv
// sequencer: loads ranges into the range ram, insertion sort in place,
// then streams the sorted ranges through the gap evaluator
// depends on lgf_pkg, lgf_ram, lgf_gap_eval
`timescale 1ns / 1ps

module lgf_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_entry_valid,
   input  logic [lgf_pkg::BLK_W-1:0]   req_range_start,
   input  logic [lgf_pkg::BLK_W-1:0]   req_range_end,
   input  logic                        req_last_item,
   input  logic [lgf_pkg::BLK_W-1:0]   first_usable,
   input  logic [lgf_pkg::BLK_W-1:0]   last_usable,
   input  logic                        rsp_slot_free,
   output logic                        rsp_push,
   output lgf_pkg::rsp_type            rsp_data
);
   import lgf_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [ENTRY_W-1:0] key_ff, key_in;
   logic [BLK_W-1:0] base_ff, base_in;
   logic             rd_pend_ff, rd_pend_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   cand_type cand;
   logic     gap_clear;
   logic     gap_busy;
   best_type best;

   logic [CNT_W-1:0] i_less1;
   logic [CNT_W-1:0] j_less1;
   logic [CNT_W-1:0] j_less2;

   assign i_less1 = i_ff - CNT_W'(1);
   assign j_less1 = j_ff - CNT_W'(1);
   assign j_less2 = j_ff - CNT_W'(2);

   lgf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgf_gap_eval u_gap_eval (
      .clock (clock),
      .reset (reset),
      .clear (gap_clear),
      .cand  (cand),
      .busy  (gap_busy),
      .best  (best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         rd_pend_ff <= rd_pend_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      key_ff  <= key_in;
      base_ff <= base_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      key_in     = key_ff;
      base_in    = base_ff;
      rd_pend_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = {req_range_start, req_range_end};
      rd_en      = 1'b0;
      rd_addr    = i_ff[ADDR_W-1:0];
      cand       = '0;
      gap_clear  = 1'b0;
      req_ready  = 1'b0;
      rsp_push   = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_entry_valid) begin
                  if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               if (req_last_item) begin
                  i_in     = CNT_W'(1);
                  state_in = ST_SORT_NEXT;
               end
            end
         end
         ST_SORT_NEXT: begin
            if (i_ff >= count_ff) begin
               k_in      = '0;
               base_in   = first_usable;
               gap_clear = 1'b1;
               state_in  = ST_SCAN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[ADDR_W-1:0];
               state_in = ST_SORT_KEY;
            end
         end
         ST_SORT_KEY: begin
            key_in   = rd_data;
            j_in     = i_ff;
            rd_en    = 1'b1;
            rd_addr  = i_less1[ADDR_W-1:0];
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            // start-major compare of packed {start, end} equals the range order
            wr_en = 1'b1;
            if (key_ff < rd_data) begin
               wr_addr = j_ff[ADDR_W-1:0];
               wr_data = rd_data;
               j_in    = j_less1;
               if (j_ff == CNT_W'(1)) begin
                  state_in = ST_SORT_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_less2[ADDR_W-1:0];
               end
            end else begin
               wr_addr  = j_ff[ADDR_W-1:0];
               wr_data  = key_ff;
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SORT_NEXT;
            end
         end
         ST_SORT_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_SORT_NEXT;
         end
         ST_SCAN: begin
            if (k_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = k_ff[ADDR_W-1:0];
               k_in       = k_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               cand.valid = 1'b1;
               cand.base  = base_ff;
               cand.bound = rd_data[ENTRY_W-1:BLK_W];
               base_in    = rd_data[BLK_W-1:0] + BLK_W'(1);
            end else if (k_ff == count_ff) begin
               // closing gap up to the last usable block
               cand.valid = 1'b1;
               cand.base  = base_ff;
               cand.bound = last_usable + BLK_W'(1);
               state_in   = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!gap_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_slot_free) begin
               rsp_push   = 1'b1;
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_data.found     = best.found;
   assign rsp_data.gap_start = best.gap_start;
   assign rsp_data.gap_end   = best.gap_end;
   assign rsp_data.overflow  = dropped_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("range count beyond capacity");
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr != rd_addr)
      else $error("read and write of the same ram entry in one cycle");
   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SORT_CMP |-> (j_ff != '0) && (j_ff <= i_ff) && (i_ff < count_ff))
      else $error("insertion index out of range");
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_slot_free && !gap_busy)
      else $error("result pushed while slot busy or scan unfinished");
`endif

endmodule
